### src/pcfe_pkg.sv
// Shared constants, types and rotation table of the polyphase channelizer front end.
package pcfe_pkg;

  localparam int CHANNELS  = 16;
  localparam int TAPS      = 8;
  localparam int PHASES    = 4;
  localparam int SMP_W     = 16;
  localparam int CH_W      = 4;
  localparam int PH_W      = 2;
  localparam int IDX_W     = 7;
  localparam int COEF_W    = 16;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 32;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_COEF = 1'b1;

  typedef logic [16:0] qmag_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] im;
    logic signed [SMP_W-1:0] re;
  } cplx_t;

  // Rounded Q15 magnitude of cos(n*pi/32) for n = 0 .. 16.
  function automatic qmag_t cos_mag(input logic [CH_W:0] n);
    qmag_t m;
    case (n)
      5'd0:    m = 17'd32768;
      5'd1:    m = 17'd32610;
      5'd2:    m = 17'd32138;
      5'd3:    m = 17'd31357;
      5'd4:    m = 17'd30274;
      5'd5:    m = 17'd28899;
      5'd6:    m = 17'd27246;
      5'd7:    m = 17'd25330;
      5'd8:    m = 17'd23170;
      5'd9:    m = 17'd20788;
      5'd10:   m = 17'd18205;
      5'd11:   m = 17'd15447;
      5'd12:   m = 17'd12540;
      5'd13:   m = 17'd9512;
      5'd14:   m = 17'd6393;
      5'd15:   m = 17'd3212;
      default: m = 17'd0;
    endcase
    return m;
  endfunction

  function automatic logic signed [SMP_W-1:0] clamp_q15(input logic signed [17:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

  // Rotation exp(j(c*pi/(2*CHANNELS) - phase*pi/2)) in Q1.15, clamped.
  function automatic cplx_t rotation(input logic [CH_W-1:0] c, input logic [PH_W-1:0] ph);
    logic signed [17:0] cq;
    logic signed [17:0] sq;
    logic signed [17:0] r_re;
    logic signed [17:0] r_im;
    cplx_t r;
    cq = signed'({1'b0, cos_mag({1'b0, c})});
    sq = signed'({1'b0, cos_mag(5'(CHANNELS) - {1'b0, c})});
    case (ph)
      2'd0: begin
        r_re = cq;
        r_im = sq;
      end
      2'd1: begin
        r_re = sq;
        r_im = -cq;
      end
      2'd2: begin
        r_re = -cq;
        r_im = -sq;
      end
      default: begin
        r_re = -sq;
        r_im = cq;
      end
    endcase
    r.re = clamp_q15(r_re);
    r.im = clamp_q15(r_im);
    return r;
  endfunction

endpackage

### src/polyphase_channelizer_front_end_top.sv
// Top level: polyphase channelizer front end, rotation and per-channel FIR on one multiplier pair.
// A data transaction holds s_axis_tready low from acceptance until its result is loaded:
// one rotation pass and one tap per cycle through the shared complex-by-real multiplier, plus
// a two-stage read and multiply pipeline drain. The result register loads only once it is free.
// A coefficient load leaves the block ready. Reset is synchronous: it clears the sequencer,
// frame position, phase and the delay-line valid bits, so every delay entry reads as zero.
module polyphase_channelizer_front_end_top #(
  parameter int TAPS   = pcfe_pkg::TAPS,
  parameter int PHASES = pcfe_pkg::PHASES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // sample [15:0], coef_index [22:16], coef_value [38:23], zero [39]
  input  logic [pcfe_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // action
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_real [15:0], out_imag [31:16]
  output logic [pcfe_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // channel
  output logic [pcfe_pkg::CH_W-1:0]        m_axis_tuser,
  output logic                             m_axis_tlast
);

  localparam int DEPTH  = pcfe_pkg::CHANNELS * TAPS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int KW     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SMP_W  = pcfe_pkg::SMP_W;
  localparam int PROD_W = 2 * SMP_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);
  localparam int CH_W   = pcfe_pkg::CH_W;
  localparam int PH_W   = pcfe_pkg::PH_W;

  typedef enum logic [2:0] {S_IDLE, S_ROT, S_NEW, S_MAC, S_DONE} state_t;

  state_t                  state;
  logic [CH_W-1:0]         pos;
  logic [PH_W-1:0]         phase;
  logic [CH_W-1:0]         chan;
  logic signed [SMP_W-1:0] sample_q;
  pcfe_pkg::cplx_t         rot;
  pcfe_pkg::cplx_t         newv;
  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic [KW-1:0]           k;
  logic                    s1_vld;
  logic [KW-1:0]           s1_k;
  logic                    s2_vld;
  logic signed [SMP_W-1:0] coef_q;
  pcfe_pkg::cplx_t         dly_q;
  logic                    dly_ok_q;
  logic signed [ACC_W-1:0] acc_re;
  logic signed [ACC_W-1:0] acc_im;
  logic signed [SMP_W-1:0] out_re;
  logic signed [SMP_W-1:0] out_im;
  logic [CH_W-1:0]         out_ch;
  logic                    out_last;
  logic                    out_vld;

  logic signed [pcfe_pkg::COEF_W-1:0] coef_mem [DEPTH];
  pcfe_pkg::cplx_t                    dly_mem  [DEPTH];
  logic [DEPTH-1:0]                   dly_vld;

  logic signed [SMP_W-1:0]        in_sample;
  logic [pcfe_pkg::IDX_W-1:0]     in_idx;
  logic signed [SMP_W-1:0]        in_coef;
  logic [CH_W-1:0]                chan_now;
  logic [ADDR_W-1:0]              base;
  logic [ADDR_W-1:0]              coef_raddr;
  logic [ADDR_W-1:0]              dly_raddr;
  logic [ADDR_W-1:0]              dly_waddr;
  pcfe_pkg::cplx_t                op;
  logic signed [SMP_W-1:0]        mul_a;
  pcfe_pkg::cplx_t                mul_b;
  logic signed [PROD_W-1:0]       mre_c;
  logic signed [PROD_W-1:0]       mim_c;
  logic                           coef_wr;
  logic                           out_load;

  function automatic logic signed [SMP_W-1:0] sat_out(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-2*SMP_W+1:0] upper;
    logic signed [SMP_W-1:0]  r;
    upper = a[ACC_W-1:2*SMP_W-2];
    if ((&upper) || !(|upper)) begin
      r = a[2*SMP_W-2:SMP_W-1];
    end else if (a[ACC_W-1]) begin
      r = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SMP_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign in_sample = s_axis_tdata[15:0];
  assign in_idx    = s_axis_tdata[22:16];
  assign in_coef   = s_axis_tdata[38:23];
  assign chan_now  = CH_W'(pcfe_pkg::CHANNELS - 1) - pos;

  assign base       = ADDR_W'(int'(chan) * TAPS);
  assign coef_raddr = ADDR_W'(int'(k) * pcfe_pkg::CHANNELS + int'(chan));
  // Tap k of the new line is tap k-1 of the old one; tap zero is the fresh rotated sample.
  assign dly_raddr  = (k == '0) ? base : ADDR_W'(int'(base) + int'(k) - 1);
  assign dly_waddr  = ADDR_W'(int'(base) + int'(s1_k));
  assign op         = (s1_k == '0) ? newv : (dly_ok_q ? dly_q : '0);

  // The one complex-by-real multiplier pair serves the rotation and every tap.
  assign mul_a = (state == S_ROT) ? sample_q : coef_q;
  assign mul_b = (state == S_ROT) ? rot : op;
  assign mre_c = mul_a * mul_b.re;
  assign mim_c = mul_a * mul_b.im;

  assign coef_wr = (state == S_IDLE) && s_axis_tvalid && (s_axis_tuser == pcfe_pkg::ACT_COEF)
                   && (int'(in_idx) < DEPTH);

  // The result register takes a new result once the pipeline has drained and it is free.
  assign out_load = (state == S_DONE) && !s1_vld && !s2_vld && (!out_vld || m_axis_tready);

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {out_im, out_re};
  assign m_axis_tuser  = out_ch;
  assign m_axis_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos     <= '0;
      phase   <= '0;
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      out_vld <= 1'b0;
      dly_vld <= '0;
    end else begin
      s1_vld   <= (state == S_MAC);
      s1_k     <= k;
      s2_vld   <= s1_vld;
      prod_re  <= mre_c;
      prod_im  <= mim_c;
      dly_ok_q <= dly_vld[dly_raddr];
      if (s1_vld) begin
        dly_vld[dly_waddr] <= 1'b1;
      end
      if (s2_vld) begin
        acc_re <= acc_re + ACC_W'(prod_re);
        acc_im <= acc_im + ACC_W'(prod_im);
      end
      if (out_vld && m_axis_tready && !out_load) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && (s_axis_tuser == pcfe_pkg::ACT_DATA)) begin
            chan     <= chan_now;
            sample_q <= in_sample;
            rot      <= pcfe_pkg::rotation(chan_now, phase);
            state    <= S_ROT;
          end
        end
        S_ROT: begin
          state <= S_NEW;
        end
        S_NEW: begin
          // Floor shift by 15, wrapped to the sample width.
          newv.re <= prod_re[2*SMP_W-2:SMP_W-1];
          newv.im <= prod_im[2*SMP_W-2:SMP_W-1];
          acc_re  <= '0;
          acc_im  <= '0;
          k       <= '0;
          state   <= S_MAC;
        end
        S_MAC: begin
          k <= k + 1'b1;
          if (k == KW'(TAPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_vld  <= 1'b1;
            out_re   <= sat_out(acc_re);
            out_im   <= sat_out(acc_im);
            out_ch   <= chan;
            out_last <= (chan == '0);
            if (chan == '0) begin
              pos   <= '0;
              phase <= (phase == PH_W'(PHASES - 1)) ? '0 : phase + 1'b1;
            end else begin
              pos <= pos + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[ADDR_W'(in_idx)] <= in_coef;
    end
    coef_q <= coef_mem[coef_raddr];
    if (s1_vld) begin
      dly_mem[dly_waddr] <= op;
    end
    dly_q <= dly_mem[dly_raddr];
  end

endmodule

### src/pcfe_checker.sv
// Port-level checker for the polyphase channelizer front end, bound to the top level.
module pcfe_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pcfe_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [pcfe_pkg::CH_W-1:0]      m_axis_tuser,
  input logic                           m_axis_tlast
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("result changed while stalled");

  // Channels run downward, so the frame ends exactly on channel zero.
  a_last_chan: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == '0)))
    else $error("tlast does not match channel zero");

  // A data transaction occupies the filter sequencer.
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    (!rst && s_axis_tvalid && s_axis_tready && (s_axis_tuser == pcfe_pkg::ACT_DATA)) |=>
      !s_axis_tready)
    else $error("ready right after a data transaction");

  // A coefficient load leaves the input ready on the next cycle.
  a_coef_fast: assert property (@(posedge clk) disable iff (rst)
    (!rst && s_axis_tvalid && s_axis_tready && (s_axis_tuser == pcfe_pkg::ACT_COEF)) |=>
      s_axis_tready)
    else $error("not ready after a coefficient load");

endmodule

bind polyphase_channelizer_front_end_top pcfe_checker u_pcfe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/testbench.sv
// Self-checking stream testbench for the polyphase channelizer front end.
`timescale 1ns / 1ps

module testbench;

  localparam int   CHANNELS  = pcfe_pkg::CHANNELS;
  localparam int   TAPS      = pcfe_pkg::TAPS;
  localparam int   PHASES    = pcfe_pkg::PHASES;
  localparam int   SMP_W     = pcfe_pkg::SMP_W;
  localparam int   CH_W      = pcfe_pkg::CH_W;
  localparam int   PH_W      = pcfe_pkg::PH_W;
  localparam int   IDX_W     = pcfe_pkg::IDX_W;
  localparam int   COEF_W    = pcfe_pkg::COEF_W;
  localparam int   S_TDATA_W = pcfe_pkg::S_TDATA_W;
  localparam int   M_TDATA_W = pcfe_pkg::M_TDATA_W;
  localparam logic ACT_DATA  = pcfe_pkg::ACT_DATA;
  localparam logic ACT_COEF  = pcfe_pkg::ACT_COEF;

  localparam int DEPTH      = CHANNELS * TAPS;
  localparam int DATA_ITEMS = 750;

  typedef struct {
    logic                     action;
    logic signed [SMP_W-1:0]  sample;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } stream_item_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
    logic                    last;
  } bin_out_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [CH_W-1:0]      m_axis_tuser;
  logic                 m_axis_tlast;

  // Own copy of the channelizer state.
  logic [CH_W-1:0]          frame_pos;
  logic [PH_W-1:0]          phase;
  logic signed [SMP_W-1:0]  line_re [DEPTH];
  logic signed [SMP_W-1:0]  line_im [DEPTH];
  logic signed [COEF_W-1:0] fir_coef [DEPTH];

  stream_item_t stim_items[$];
  bin_out_t     filtered_due[$];
  stream_item_t offer;
  bit           offer_taken;
  int           cycle;
  int           results_seen;
  int           mismatches;
  int           hold_left;
  bit           held_once;

  polyphase_channelizer_front_end_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Random breaks on both sides pause during the last quarter of each window of the cycle count.
  function automatic bit take_break();
    return ((cycle % 8000) < 6000) && ($urandom_range(0, 99) < 12);
  endfunction

  function automatic int q15_round(input real v);
    return $rtoi(v * 32768.0 + 0.5);
  endfunction

  function automatic void channelize_sample(input logic signed [SMP_W-1:0] smp);
    int       c;
    int       base;
    int       k;
    int       cq;
    int       sq;
    int       rot_re;
    int       rot_im;
    real      ang;
    longint   acc_re;
    longint   acc_im;
    bin_out_t r;
    c   = CHANNELS - 1 - int'(frame_pos);
    ang = real'(c) * 3.14159265358979323846 / (2.0 * CHANNELS);
    cq  = q15_round($cos(ang));
    sq  = q15_round($sin(ang));
    case (phase)
      2'd0: begin
        rot_re = cq;
        rot_im = sq;
      end
      2'd1: begin
        rot_re = sq;
        rot_im = -cq;
      end
      2'd2: begin
        rot_re = -cq;
        rot_im = -sq;
      end
      default: begin
        rot_re = -sq;
        rot_im = cq;
      end
    endcase
    // Only +1.0 can fall outside Q1.15; -1.0 fits.
    if (rot_re > 32767) rot_re = 32767;
    if (rot_im > 32767) rot_im = 32767;

    base = c * TAPS;
    for (k = TAPS - 1; k > 0; k--) begin
      line_re[base + k] = line_re[base + k - 1];
      line_im[base + k] = line_im[base + k - 1];
    end
    // The rotated sample wraps to the sample width, it does not saturate.
    line_re[base] = SMP_W'((longint'(smp) * rot_re) >>> 15);
    line_im[base] = SMP_W'((longint'(smp) * rot_im) >>> 15);

    acc_re = 0;
    acc_im = 0;
    for (k = 0; k < TAPS; k++) begin
      acc_re += longint'(fir_coef[c + k * CHANNELS]) * longint'(line_re[base + k]);
      acc_im += longint'(fir_coef[c + k * CHANNELS]) * longint'(line_im[base + k]);
    end
    acc_re = acc_re >>> 15;
    acc_im = acc_im >>> 15;
    if (acc_re > 32767) acc_re = 32767;
    if (acc_re < -32768) acc_re = -32768;
    if (acc_im > 32767) acc_im = 32767;
    if (acc_im < -32768) acc_im = -32768;

    r.channel = CH_W'(c);
    r.re      = SMP_W'(acc_re);
    r.im      = SMP_W'(acc_im);
    r.last    = (frame_pos == CH_W'(CHANNELS - 1));
    filtered_due.push_back(r);

    if (r.last) begin
      frame_pos = '0;
      phase     = (phase == PH_W'(PHASES - 1)) ? '0 : phase + 1'b1;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
  endfunction

  task automatic push_coef(input logic [IDX_W-1:0] idx, input logic signed [COEF_W-1:0] val);
    stream_item_t it;
    it.action     = ACT_COEF;
    it.sample     = SMP_W'($urandom);
    it.coef_index = idx;
    it.coef_value = val;
    stim_items.push_back(it);
  endtask

  task automatic push_sample(input logic signed [SMP_W-1:0] val);
    stream_item_t it;
    it.action     = ACT_DATA;
    it.sample     = val;
    it.coef_index = IDX_W'($urandom);
    it.coef_value = COEF_W'($urandom);
    stim_items.push_back(it);
  endtask

  // Styles: 0 random, 1 all +max, 2 all -max, 3 sign pairs that line up with the
  // rotation cycle (drives the sums into saturation), 4 small values.
  task automatic load_coef_set(input int style);
    int                       i;
    int                       tap;
    logic signed [COEF_W-1:0] v;
    for (i = 0; i < DEPTH; i++) begin
      tap = i / CHANNELS;
      case (style)
        0:       v = COEF_W'($urandom);
        1:       v = 16'sh7fff;
        2:       v = 16'sh8000;
        3:       v = ((tap / 2) % 2 != 0) ? 16'sh8000 : 16'sh7fff;
        default: v = COEF_W'(int'($urandom_range(0, 256)) - 128);
      endcase
      push_coef(IDX_W'(i), v);
    end
  endtask

  initial begin : stimulus
    int                      data_left;
    int                      seg_len;
    int                      s_style;
    int                      k;
    logic signed [SMP_W-1:0] hold_val;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_DATA;
    m_axis_tready = 1'b0;

    // Every coefficient is written before the first data sample.
    load_coef_set(3);

    // Directed: sample extremes, and coefficient loads in the middle of a frame.
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    push_sample(16'sh0000);
    push_sample(16'shffff);
    push_sample(16'sh0001);
    push_sample(16'sh5555);
    push_sample(16'shaaaa);
    push_coef(7'd127, 16'sh7fff);
    push_coef(7'd0, 16'sh8000);
    push_sample(16'sh8000);
    for (k = 0; k < 10; k++) push_sample(16'sh7fff);
    push_coef(7'd127, 16'sh8000);
    push_coef(7'd0, 16'sh7fff);

    data_left = DATA_ITEMS;
    while (data_left > 0) begin
      if ($urandom_range(0, 9) < 2) begin
        load_coef_set($urandom_range(0, 4));
      end else begin
        repeat ($urandom_range(0, 6)) push_coef(IDX_W'($urandom), COEF_W'($urandom));
      end
      s_style  = $urandom_range(0, 3);
      hold_val = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      seg_len  = $urandom_range(8, 120);
      for (k = 0; k < seg_len && data_left > 0; k++) begin
        if ($urandom_range(0, 99) < 4) push_coef(IDX_W'($urandom), COEF_W'($urandom));
        case (s_style)
          0:       push_sample(SMP_W'($urandom));
          1:       push_sample(($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000);
          2:       push_sample(SMP_W'(int'($urandom_range(0, 8)) - 4));
          default: push_sample(hold_val);
        endcase
        data_left--;
      end
    end

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    while (stim_items.size() != 0 || s_axis_tvalid || filtered_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (2 * TAPS + 12) @(posedge clk);

    if (mismatches == 0 && filtered_due.size() == 0) begin
      $display("** polyphase_channelizer_front_end_top: PASSED **");
    end else begin
      $display("** polyphase_channelizer_front_end_top: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("** polyphase_channelizer_front_end_top: FAILED **");
    $finish;
  end

  // Sender: a transaction stays on the bus until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || offer_taken) begin
      if (stim_items.size() != 0 && !take_break()) begin
        offer = stim_items.pop_front();
        s_axis_tdata  <= {1'b0, offer.coef_value, offer.coef_index, offer.sample};
        s_axis_tuser  <= offer.action;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      offer_taken = 1'b0;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off that fills the block up.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!held_once && results_seen >= 300) begin
      held_once = 1'b1;
      hold_left = 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !take_break();
    end
  end

  always @(posedge clk) begin : monitor
    bin_out_t got;
    bin_out_t want;
    if (rst) begin
      frame_pos = '0;
      phase     = '0;
      for (int i = 0; i < DEPTH; i++) begin
        line_re[i] = '0;
        line_im[i] = '0;
      end
    end else begin
      cycle++;
      if (s_axis_tvalid && s_axis_tready) begin
        offer_taken = 1'b1;
        if (offer.action == ACT_COEF) begin
          fir_coef[offer.coef_index] = offer.coef_value;
        end else begin
          channelize_sample(offer.sample);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.channel = m_axis_tuser;
        got.re      = m_axis_tdata[15:0];
        got.im      = m_axis_tdata[31:16];
        got.last    = m_axis_tlast;
        results_seen++;
        if (filtered_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result ch=%0d re=%0d im=%0d last=%0b",
                     $realtime, got.channel, got.re, got.im, got.last);
          end
        end else begin
          want = filtered_due.pop_front();
          if (got.channel !== want.channel || got.re !== want.re ||
              got.im !== want.im || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d expected ch=%0d re=%0d im=%0d last=%0b",
                       $realtime, results_seen, want.channel, want.re, want.im, want.last);
              $display("%0t: result %0d actual   ch=%0d re=%0d im=%0d last=%0b",
                       $realtime, results_seen, got.channel, got.re, got.im, got.last);
            end
          end
        end
      end
    end
  end

endmodule
